>>> design/u16rf_pkg.sv
`default_nettype none

package u16rf_pkg;

  // Guest register window sits at I/O base 0x3F8; only the offset arrives here.

  localparam int unsigned DEFAULT_RESET_DIVISOR = 1;

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 48;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_POLL  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    OFF_RBR = 3'd0,
    OFF_IER = 3'd1,
    OFF_IIR = 3'd2,
    OFF_LCR = 3'd3,
    OFF_MCR = 3'd4,
    OFF_LSR = 3'd5,
    OFF_MSR = 3'd6,
    OFF_SCR = 3'd7
  } off_t;

  localparam logic [7:0] LCR_RESET     = 8'h03;
  localparam logic [7:0] IIR_RX_DATA   = 8'hC4;
  localparam logic [7:0] IIR_NONE      = 8'hC1;
  localparam logic [7:0] MSR_FIXED     = 8'hB0;
  localparam logic [7:0] LSR_THR_EMPTY = 8'h60;

  localparam int unsigned LCR_DLAB_BIT  = 7;
  localparam int unsigned MCR_OUT2_BIT  = 3;
  localparam int unsigned MCR_LOOP_BIT  = 4;
  localparam int unsigned IER_RX_BIT    = 0;
  localparam int unsigned FCR_EN_BIT    = 0;
  localparam int unsigned FCR_RXCLR_BIT = 1;
  localparam int unsigned FCR_TXCLR_BIT = 2;

  typedef struct packed {
    op_t        op;
    off_t       reg_offset;
    logic [7:0] write_data;
    logic       rx_available;
    logic       tx_ready;
    logic [7:0] rx_byte;
    logic [3:0] rx_flags;
  } item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        rx_pop;
    logic        tx_push;
    logic [7:0]  tx_byte;
    logic        irq_request;
    logic        format_changed;
    logic [15:0] divisor;
    logic [7:0]  line_control;
    logic        loopback;
    logic        rx_flush;
    logic        tx_flush;
    logic        fifo_enable;
  } result_t;

  // err: bit0 OE, bit1 PE, bit2 FE, bit3 BI (LSR bits 1..4)
  typedef struct packed {
    logic [7:0] lcr;
    logic [7:0] ier;
    logic [7:0] mcr;
    logic [7:0] fcr;
    logic [7:0] dll;
    logic [7:0] dlm;
    logic [7:0] scr;
    logic [7:0] last_rx;
    logic [3:0] err;
    logic       armed;
  } state_t;

endpackage

`default_nettype wire

>>> design/u16rf_step.sv
`default_nettype none

module u16rf_step (
  input  u16rf_pkg::item_t   item,
  input  u16rf_pkg::state_t  st,
  output u16rf_pkg::result_t res,
  output u16rf_pkg::state_t  st_next
);
  import u16rf_pkg::*;

  logic dlab;

  assign dlab = st.lcr[LCR_DLAB_BIT];

  always_comb begin
    st_next = st;
    res     = '0;
    unique case (item.op)
      OP_READ: begin
        unique case (item.reg_offset)
          OFF_RBR: begin
            if (dlab) begin
              res.read_data = st.dll;
            end else if (item.rx_available) begin
              res.read_data   = item.rx_byte;
              res.rx_pop      = 1'b1;
              st_next.last_rx = item.rx_byte;
              // flags FE,PE,BI,OE reordered into OE,PE,FE,BI
              st_next.err     = st.err | {item.rx_flags[2], item.rx_flags[0],
                                          item.rx_flags[1], item.rx_flags[3]};
              st_next.armed   = 1'b0;
            end else begin
              res.read_data = st.last_rx;
            end
          end
          OFF_IER: res.read_data = dlab ? st.dlm : st.ier;
          OFF_IIR: res.read_data = (st.ier[IER_RX_BIT] && item.rx_available) ?
                                   IIR_RX_DATA : IIR_NONE;
          OFF_LCR: res.read_data = st.lcr;
          OFF_MCR: res.read_data = st.mcr;
          OFF_LSR: begin
            res.read_data = (item.tx_ready ? LSR_THR_EMPTY : 8'h00) |
                            {3'b000, st.err, item.rx_available};
            st_next.err   = '0;
          end
          OFF_MSR: res.read_data = MSR_FIXED;
          OFF_SCR: res.read_data = st.scr;
        endcase
      end
      OP_WRITE: begin
        unique case (item.reg_offset)
          OFF_RBR: begin
            if (dlab) begin
              st_next.dll        = item.write_data;
              res.format_changed = 1'b1;
            end else if (item.tx_ready) begin
              res.tx_push = 1'b1;
              res.tx_byte = item.write_data;
            end
          end
          OFF_IER: begin
            if (dlab) begin
              st_next.dlm        = item.write_data;
              res.format_changed = 1'b1;
            end else begin
              // rising receive-enable rearms the interrupt
              if (!st.ier[IER_RX_BIT] && item.write_data[IER_RX_BIT]) begin
                st_next.armed = 1'b0;
              end
              st_next.ier = item.write_data;
            end
          end
          OFF_IIR: begin
            if (item.write_data[FCR_RXCLR_BIT]) begin
              res.rx_flush  = 1'b1;
              st_next.err   = '0;
              st_next.armed = 1'b0;
            end
            res.tx_flush = item.write_data[FCR_TXCLR_BIT];
            st_next.fcr  = item.write_data;
          end
          OFF_LCR: begin
            st_next.lcr        = item.write_data;
            res.format_changed = 1'b1;
          end
          OFF_MCR: begin
            st_next.mcr = item.write_data;
            if (!item.write_data[MCR_OUT2_BIT]) begin
              st_next.armed = 1'b0;
            end
          end
          OFF_LSR, OFF_MSR: ;
          OFF_SCR: st_next.scr = item.write_data;
        endcase
      end
      OP_POLL: begin
        if (st.mcr[MCR_OUT2_BIT] && st.ier[IER_RX_BIT] && item.rx_available && !st.armed) begin
          st_next.armed   = 1'b1;
          res.irq_request = 1'b1;
        end else if (!item.rx_available) begin
          st_next.armed = 1'b0;
        end
      end
      OP_NONE: ;
    endcase

    res.divisor      = {st_next.dlm, st_next.dll};
    res.line_control = st_next.lcr;
    res.loopback     = st_next.mcr[MCR_LOOP_BIT];
    res.fifo_enable  = st_next.fcr[FCR_EN_BIT];
  end

endmodule

`default_nettype wire

>>> design/uart_16550_register_front_core.sv
// 16550-style register front for a plain UART backend. Each slave item is a guest
// register read, a guest register write, an interrupt poll or a no-op (tuser), with a
// snapshot of the backend status and receive head byte; each produces exactly one
// master item carrying the read data, backend strobes (pop, push, flushes) and the
// current format outputs. An item passes through the input register, then the decode
// and register update into the result register, and a new item is accepted every
// cycle while the input register is empty or advancing; the register file update is
// the loop that sets this rate. A result waiting on m_tready stalls only once the input
// register is also full.
`default_nettype none

module uart_16550_register_front_core #(
  parameter int unsigned RESET_DIVISOR = u16rf_pkg::DEFAULT_RESET_DIVISOR
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               s_tvalid,
  output logic                              s_tready,
  // reg_offset[2:0], write_data[10:3], rx_available[11], tx_ready[12],
  // rx_byte[20:13], rx_flags[24:21], zero fill [31:25]
  input  wire  [u16rf_pkg::IN_DATA_W-1:0]   s_tdata,
  // op[1:0]
  input  wire  [u16rf_pkg::IN_USER_W-1:0]   s_tuser,
  output logic                              m_tvalid,
  input  wire                               m_tready,
  // read_data[7:0], rx_pop[8], tx_push[9], tx_byte[17:10], irq_request[18],
  // format_changed[19], divisor[35:20], line_control[43:36], loopback[44],
  // rx_flush[45], tx_flush[46], fifo_enable[47]
  output logic [u16rf_pkg::OUT_DATA_W-1:0]  m_tdata
);
  import u16rf_pkg::*;

  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t out_res;
  state_t  st;
  state_t  st_next;
  result_t step_res;
  logic    adv;

  assign adv      = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || adv;

  u16rf_step u_step (
    .item    (in_item),
    .st      (st),
    .res     (step_res),
    .st_next (st_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= '{lcr: LCR_RESET, dll: RESET_DIVISOR[7:0], default: '0};
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (adv) begin
        in_valid <= 1'b0;
      end
      if (adv) begin
        out_valid <= 1'b1;
        st        <= st_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.op           <= op_t'(s_tuser);
      in_item.reg_offset   <= off_t'(s_tdata[2:0]);
      in_item.write_data   <= s_tdata[10:3];
      in_item.rx_available <= s_tdata[11];
      in_item.tx_ready     <= s_tdata[12];
      in_item.rx_byte      <= s_tdata[20:13];
      in_item.rx_flags     <= s_tdata[24:21];
    end
    if (adv) begin
      out_res <= step_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_res.fifo_enable, out_res.tx_flush, out_res.rx_flush,
                     out_res.loopback, out_res.line_control, out_res.divisor,
                     out_res.format_changed, out_res.irq_request, out_res.tx_byte,
                     out_res.tx_push, out_res.rx_pop, out_res.read_data};

`ifndef SYNTHESIS
  a_reset_lcr : assert property (@(posedge clk) rst |=> st.lcr == LCR_RESET)
    else $error("line control not at reset value");

  a_pop_disarms : assert property (@(posedge clk) disable iff (rst)
    (adv && step_res.rx_pop) |=> !st.armed)
    else $error("receive pop left interrupt armed");

  a_irq_arms : assert property (@(posedge clk) disable iff (rst)
    (adv && step_res.irq_request) |=> st.armed)
    else $error("interrupt request did not arm");

  a_divisor_tracks : assert property (@(posedge clk) disable iff (rst)
    adv |=> out_res.divisor == {st.dlm, st.dll})
    else $error("divisor output out of step with registers");

  a_pop_push_excl : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_res.rx_pop && out_res.tx_push))
    else $error("pop and push in one item");
`endif

endmodule

`default_nettype wire
